// File: design/stream_frame_header_parser_core_assert.svh
// assertion macros used by the port-level checker file
`ifndef STREAM_FRAME_HEADER_PARSER_CORE_ASSERT_SVH
`define STREAM_FRAME_HEADER_PARSER_CORE_ASSERT_SVH

// same-cycle implication
`define FSH_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fsh assertion failed");

// next-cycle implication
`define FSH_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fsh assertion failed");

`endif

// File: design/fsh_pkg.sv
// shared constants and types of the stream frame header parser
package fsh_pkg;

    localparam int POSITION_BITS   = 16;
    localparam int VARINT_BITS     = 62;
    localparam int END_OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [VARINT_BITS-1:0] MAX_POS =
        (VARINT_BITS'(1) << POSITION_BITS) - VARINT_BITS'(1);

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_HEADER  = 2'd0;
    localparam kind_t KIND_PAYLOAD = 2'd1;
    localparam kind_t KIND_DONE    = 2'd2;
    localparam kind_t KIND_ERROR   = 2'd3;

    // one queue entry describes the one or two results of a word
    typedef struct packed {
        logic                     two;
        kind_t                    kind0;
        kind_t                    kind1;
        logic [VARINT_BITS-1:0]   sid_value;
        logic [VARINT_BITS-1:0]   offset_value;
        logic [VARINT_BITS-1:0]   length_value;
        logic                     fin;
        logic [7:0]               payload_byte;
        logic [POSITION_BITS-1:0] end_pos;
    } fsh_entry_t;

    typedef struct packed {
        logic       push;
        fsh_entry_t entry;
    } fsh_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fsh_qstat_t;

endpackage

// File: design/fsh_front.sv
// front end: takes words, walks the header and payload, queues result entries
module fsh_front import fsh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_of_buffer,
    input  fsh_qstat_t qstat,
    output fsh_push_t  qpush
);

    localparam logic [2:0] PH_TYPE    = 3'd0;
    localparam logic [2:0] PH_SID     = 3'd1;
    localparam logic [2:0] PH_OFF     = 3'd2;
    localparam logic [2:0] PH_LEN     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DRAIN   = 3'd5;

    logic [2:0]               phase_reg, phase_next;
    logic [VARINT_BITS-1:0]   acc_reg, acc_next;
    logic [2:0]               left_reg, left_next;
    logic [VARINT_BITS-1:0]   sid_reg, sid_next;
    logic [VARINT_BITS-1:0]   off_reg, off_next;
    logic                     fin_reg, fin_next;
    logic                     offp_reg, offp_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;
    logic [POSITION_BITS-1:0] pl_reg, pl_next;

    logic                     accept;
    logic [VARINT_BITS-1:0]   acc_feed;
    logic [2:0]               left_feed;
    logic                     feed_done;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [VARINT_BITS-1:0]   limit;
    logic                     too_long;
    logic [1:0]               cnt;
    kind_t                    kind0, kind1;

    assign s_ready = !qstat.full;
    assign accept  = s_valid && s_ready;
    assign pos_inc = pos_reg + POSITION_BITS'(1);
    assign limit   = MAX_POS - VARINT_BITS'(pos_inc);

    // varint byte step
    always_comb begin
        if (left_reg == 3'd0) begin
            acc_feed = VARINT_BITS'(s_data_byte[5:0]);
            unique case (s_data_byte[7:6])
                2'd0: left_feed = 3'd0;
                2'd1: left_feed = 3'd1;
                2'd2: left_feed = 3'd3;
                2'd3: left_feed = 3'd7;
            endcase
        end else begin
            acc_feed  = {acc_reg[VARINT_BITS-9:0], s_data_byte};
            left_feed = left_reg - 3'd1;
        end
    end

    assign feed_done = (left_feed == 3'd0);
    assign too_long  = acc_feed > limit;

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        sid_next   = sid_reg;
        off_next   = off_reg;
        fin_next   = fin_reg;
        offp_next  = offp_reg;
        pos_next   = pos_reg;
        pl_next    = pl_reg;
        cnt        = 2'd0;
        kind0      = KIND_ERROR;
        kind1      = KIND_ERROR;

        unique case (phase_reg)
            PH_TYPE: begin
                fin_next   = s_data_byte[0];
                offp_next  = s_data_byte[2];
                pos_next   = POSITION_BITS'(1);
                acc_next   = '0;
                left_next  = 3'd0;
                sid_next   = '0;
                off_next   = '0;
                pl_next    = '0;
                phase_next = PH_SID;
            end
            PH_SID, PH_OFF, PH_LEN: begin
                pos_next  = pos_inc;
                acc_next  = acc_feed;
                left_next = left_feed;
                if (feed_done) begin
                    if (phase_reg == PH_SID) begin
                        sid_next   = acc_feed;
                        phase_next = offp_reg ? PH_OFF : PH_LEN;
                    end else if (phase_reg == PH_OFF) begin
                        off_next   = acc_feed;
                        phase_next = PH_LEN;
                    end else if (too_long) begin
                        kind0      = KIND_ERROR;
                        cnt        = 2'd1;
                        phase_next = PH_DRAIN;
                    end else begin
                        kind0   = KIND_HEADER;
                        pl_next = acc_feed[POSITION_BITS-1:0];
                        if (acc_feed == '0) begin
                            kind1      = KIND_DONE;
                            cnt        = 2'd2;
                            phase_next = PH_DRAIN;
                        end else begin
                            cnt        = 2'd1;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                pos_next = pos_inc;
                pl_next  = pl_reg - POSITION_BITS'(1);
                kind0    = KIND_PAYLOAD;
                if (pl_reg == POSITION_BITS'(1)) begin
                    kind1      = KIND_DONE;
                    cnt        = 2'd2;
                    phase_next = PH_DRAIN;
                end else begin
                    cnt = 2'd1;
                end
            end
            default: begin
                phase_next = PH_DRAIN;
            end
        endcase

        if (s_last_of_buffer) begin
            // buffer ended with the frame unfinished
            if (phase_next != PH_DRAIN && cnt != 2'd2) begin
                if (cnt == 2'd0) begin
                    kind0 = KIND_ERROR;
                    cnt   = 2'd1;
                end else begin
                    kind1 = KIND_ERROR;
                    cnt   = 2'd2;
                end
            end
            phase_next = PH_TYPE;
            acc_next   = '0;
            left_next  = 3'd0;
            sid_next   = '0;
            off_next   = '0;
            fin_next   = 1'b0;
            offp_next  = 1'b0;
            pos_next   = '0;
            pl_next    = '0;
        end
    end

    always_comb begin
        qpush.push               = accept && (cnt != 2'd0);
        qpush.entry.two          = (cnt == 2'd2);
        qpush.entry.kind0        = kind0;
        qpush.entry.kind1        = kind1;
        qpush.entry.sid_value    = sid_reg;
        qpush.entry.offset_value = off_reg;
        qpush.entry.length_value = acc_feed;
        qpush.entry.fin          = fin_reg;
        qpush.entry.payload_byte = s_data_byte;
        qpush.entry.end_pos      = pos_inc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TYPE;
            acc_reg   <= '0;
            left_reg  <= 3'd0;
            sid_reg   <= '0;
            off_reg   <= '0;
            fin_reg   <= 1'b0;
            offp_reg  <= 1'b0;
            pos_reg   <= '0;
            pl_reg    <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            sid_reg   <= sid_next;
            off_reg   <= off_next;
            fin_reg   <= fin_next;
            offp_reg  <= offp_next;
            pos_reg   <= pos_next;
            pl_reg    <= pl_next;
        end
    end

endmodule

// File: design/fsh_queue.sv
// short register queue of result entries between front and back
module fsh_queue import fsh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  fsh_push_t  qpush,
    input  logic       pop,
    output fsh_entry_t head,
    output fsh_qstat_t qstat
);

    fsh_entry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_BITS'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (qpush.push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QPTR_BITS'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QPTR_BITS'(1);
        end
        priority if (qpush.push && !pop) begin
            count_next = count_reg + QCNT_BITS'(1);
        end else if (pop && !qpush.push) begin
            count_next = count_reg - QCNT_BITS'(1);
        end else begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (qpush.push) begin
            slot_reg[wr_ptr_reg] <= qpush.entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: design/fsh_back.sv
// back end: expands queued entries into result words in an output register
module fsh_back import fsh_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  fsh_entry_t                 head,
    input  fsh_qstat_t                 qstat,
    output logic                       pop,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [VARINT_BITS-1:0]     m_sid_value,
    output logic [VARINT_BITS-1:0]     m_offset_value,
    output logic [VARINT_BITS-1:0]     m_length_value,
    output logic                       m_fin,
    output logic [7:0]                 m_payload_byte,
    output logic [END_OFFSET_BITS-1:0] m_end_offset,
    output logic                       m_last_of_run
);

    logic                       valid_reg;
    logic                       idx_reg;
    kind_t                      kind_reg;
    logic [VARINT_BITS-1:0]     sid_reg;
    logic [VARINT_BITS-1:0]     off_reg;
    logic [VARINT_BITS-1:0]     len_reg;
    logic                       fin_reg;
    logic [7:0]                 pbyte_reg;
    logic [END_OFFSET_BITS-1:0] endoff_reg;
    logic                       last_reg;

    logic                       load;
    kind_t                      kind_sel;
    logic                       last_sel;
    logic [VARINT_BITS-1:0]     sid_sel, off_sel, len_sel;
    logic                       fin_sel;
    logic [7:0]                 pbyte_sel;
    logic [END_OFFSET_BITS-1:0] endoff_sel;

    assign load     = !qstat.empty && (!valid_reg || m_ready);
    assign kind_sel = idx_reg ? head.kind1 : head.kind0;
    assign last_sel = idx_reg || !head.two;
    assign pop      = load && last_sel;

    // fields that do not belong to the kind read as zero
    always_comb begin
        sid_sel    = '0;
        off_sel    = '0;
        len_sel    = '0;
        fin_sel    = 1'b0;
        pbyte_sel  = '0;
        endoff_sel = '0;
        if (!qstat.empty) begin
            unique case (kind_sel)
                KIND_HEADER: begin
                    sid_sel = head.sid_value;
                    off_sel = head.offset_value;
                    len_sel = head.length_value;
                    fin_sel = head.fin;
                end
                KIND_PAYLOAD: begin
                    pbyte_sel = head.payload_byte;
                end
                KIND_DONE: begin
                    endoff_sel = END_OFFSET_BITS'(head.end_pos);
                end
                KIND_ERROR: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= !last_sel;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg   <= kind_sel;
            sid_reg    <= sid_sel;
            off_reg    <= off_sel;
            len_reg    <= len_sel;
            fin_reg    <= fin_sel;
            pbyte_reg  <= pbyte_sel;
            endoff_reg <= endoff_sel;
            last_reg   <= last_sel;
        end
    end

    assign m_valid        = valid_reg;
    assign m_kind         = kind_reg;
    assign m_sid_value    = sid_reg;
    assign m_offset_value = off_reg;
    assign m_length_value = len_reg;
    assign m_fin          = fin_reg;
    assign m_payload_byte = pbyte_reg;
    assign m_end_offset   = endoff_reg;
    assign m_last_of_run  = last_reg;

endmodule

// File: design/stream_frame_header_parser_core.sv
// a word's results pass through a queue slot register, then the back-end output register
// one input word per cycle while s_ready, one result word per cycle while m_ready
// a word with two results holds the back end for both; the 4-entry queue absorbs this
// ready falls only while the result queue is full
// reset: synchronous active-low aresetn clears the parser state, the queue and the output
module stream_frame_header_parser_core import fsh_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_data_byte,
    input  logic                       s_last_of_buffer,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_kind,
    output logic [VARINT_BITS-1:0]     m_sid_value,
    output logic [VARINT_BITS-1:0]     m_offset_value,
    output logic [VARINT_BITS-1:0]     m_length_value,
    output logic                       m_fin,
    output logic [7:0]                 m_payload_byte,
    output logic [END_OFFSET_BITS-1:0] m_end_offset,
    output logic                       m_last_of_run
);

    fsh_push_t  qpush;
    fsh_qstat_t qstat;
    fsh_entry_t head;
    logic       pop;

    fsh_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .s_last_of_buffer (s_last_of_buffer),
        .qstat            (qstat),
        .qpush            (qpush)
    );

    fsh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qpush   (qpush),
        .pop     (pop),
        .head    (head),
        .qstat   (qstat)
    );

    fsh_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .qstat          (qstat),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_sid_value    (m_sid_value),
        .m_offset_value (m_offset_value),
        .m_length_value (m_length_value),
        .m_fin          (m_fin),
        .m_payload_byte (m_payload_byte),
        .m_end_offset   (m_end_offset),
        .m_last_of_run  (m_last_of_run)
    );

endmodule

// File: design/fsh_checker.sv
// port-level checker for the parser and its bind
`include "stream_frame_header_parser_core_assert.svh"

module fsh_checker import fsh_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [1:0]                 m_kind,
    input logic [VARINT_BITS-1:0]     m_sid_value,
    input logic [VARINT_BITS-1:0]     m_offset_value,
    input logic [VARINT_BITS-1:0]     m_length_value,
    input logic                       m_fin,
    input logic [7:0]                 m_payload_byte,
    input logic [END_OFFSET_BITS-1:0] m_end_offset,
    input logic                       m_last_of_run
);

    // stalled result word holds
    `FSH_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable(m_kind) && $stable(m_sid_value) && $stable(m_payload_byte)
        && $stable(m_end_offset) && $stable(m_last_of_run))

    // a non-final result is followed at once by a done or error word
    `FSH_ASSERT_NXT(a_second_follows, aclk, aresetn, m_valid && m_ready && !m_last_of_run,
        m_valid && (m_kind == KIND_DONE || m_kind == KIND_ERROR))

    // header fields are zero outside header words
    `FSH_ASSERT_IMP(a_hdr_zero, aclk, aresetn, m_valid && m_kind != KIND_HEADER,
        m_sid_value == '0 && m_offset_value == '0 && m_length_value == '0 && !m_fin)

    // the payload byte is zero outside payload words
    `FSH_ASSERT_IMP(a_pbyte_zero, aclk, aresetn, m_valid && m_kind != KIND_PAYLOAD,
        m_payload_byte == '0)

endmodule

bind stream_frame_header_parser_core fsh_checker u_fsh_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_kind         (m_kind),
    .m_sid_value    (m_sid_value),
    .m_offset_value (m_offset_value),
    .m_length_value (m_length_value),
    .m_fin          (m_fin),
    .m_payload_byte (m_payload_byte),
    .m_end_offset   (m_end_offset),
    .m_last_of_run  (m_last_of_run)
);
